// ===== rtl/core/twb_pkg.sv =====
`default_nettype none
package twb_pkg;
    localparam int EVENT_DEPTH  = 256;
    localparam int REF_DEPTH    = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int EV_AW  = $clog2(EVENT_DEPTH);
    localparam int EV_CW  = $clog2(EVENT_DEPTH + 1);
    localparam int REF_AW = $clog2(REF_DEPTH);
    localparam int REF_CW = $clog2(REF_DEPTH + 1);
    localparam logic [63:0] OFFSET_RESET = 64'd1000000;

    typedef enum logic [2:0] {
        ACT_ADD_EVENT = 3'd0,
        ACT_ADD_REF   = 3'd1,
        ACT_CLOSE     = 3'd2,
        ACT_REPORT    = 3'd3,
        ACT_CULL      = 3'd4,
        ACT_CLEAR     = 3'd5,
        ACT_READ      = 3'd6
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_RD_WAIT, ST_CL_FIRST, ST_CL_QRD, ST_CL_QCHK,
        ST_CL_SHIFT, ST_CL_SCAN_RD, ST_CL_SCAN_CHK, ST_CU_RD, ST_CU_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic rd_capture;
        logic cl_first;
        logic q_issue;
        logic q_check;
        logic q_shift;
        logic scan_issue;
        logic scan_check;
        logic cu_issue;
        logic cu_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    close_empty;
        logic    q_done;
        logic    q_found;
        logic    shift_done;
        logic    scan_done;
        logic    cu_done;
    } sts_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/twb_in_if.sv =====
`default_nettype none
interface twb_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [63:0] time_value;
    logic [31:0] event_payload;
    logic [8:0]  cull_count;
    logic [7:0]  read_index;
    modport source (output valid, action, time_value, event_payload, cull_count, read_index,
                    input ready);
    modport sink (input valid, action, time_value, event_payload, cull_count, read_index,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/twb_out_if.sv =====
`default_nettype none
interface twb_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [8:0]  ready_count;
    logic [63:0] batch_ref_time;
    logic [63:0] entry_time;
    logic [31:0] entry_payload;
    modport source (output valid, accepted, ready_count, batch_ref_time, entry_time,
                    entry_payload, input ready);
    modport sink (input valid, accepted, ready_count, batch_ref_time, entry_time,
                  entry_payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/time_window_event_batcher.sv =====
`default_nettype none
// Time-window event batcher. Each transfer on in_ch carries one action and yields exactly
// one result transfer on out_ch. Add event/reference, report all, clear and unknown
// actions pass through the exec and done states; read entry adds a state for the
// registered memory read. Close window walks the reference queue newest first, shifts
// the queue when a match is found, then scans the event buffer from the oldest entry up
// to the first one past the window. Cull copies each kept event down to its new slot,
// one event at a time. The result register frees the output side: a new item is taken
// in the cycle its predecessor's result is transferred. The user must write
// max_offset_time through cfg_we/cfg_data only while the block is idle; the block
// itself does not enforce this.
module time_window_event_batcher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_data,
    twb_in_if.sink           in_ch,
    twb_out_if.source        out_ch
);
    import twb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // controller: sequencing and handshake
    twb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: stores, window math, result register
    twb_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .action         (in_ch.action),
        .time_value     (in_ch.time_value),
        .event_payload  (in_ch.event_payload),
        .cull_count     (in_ch.cull_count),
        .read_index     (in_ch.read_index),
        .cmd            (cmd),
        .sts            (sts),
        .accepted       (out_ch.accepted),
        .ready_count    (out_ch.ready_count),
        .batch_ref_time (out_ch.batch_ref_time),
        .entry_time     (out_ch.entry_time),
        .entry_payload  (out_ch.entry_payload)
    );
endmodule
`default_nettype wire

// ===== rtl/core/twb_ctrl.sv =====
`default_nettype none
module twb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    input  wire twb_pkg::sts_t sts,
    output twb_pkg::cmd_t      cmd
);
    import twb_pkg::*;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;
    logic   done;

    assign done = (state_reg == ST_DONE);
    // result register frees when taken; accept next item only once it is free
    assign in_ready  = (state_reg == ST_IDLE) && (!ovalid_reg || out_ready);
    assign out_valid = ovalid_reg;
    assign ovalid_next = done ? 1'b1 : (out_ready ? 1'b0 : ovalid_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (in_valid && in_ready) state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (sts.action)
                    ACT_READ:  state_next = ST_RD_WAIT;
                    ACT_CLOSE: state_next = sts.close_empty ? ST_DONE : ST_CL_FIRST;
                    ACT_CULL:  state_next = ST_CU_RD;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_RD_WAIT:     state_next = ST_DONE;
            ST_CL_FIRST:    state_next = ST_CL_QRD;
            ST_CL_QRD:      state_next = sts.q_done ? ST_CL_SCAN_RD : ST_CL_QCHK;
            ST_CL_QCHK:     state_next = sts.q_found ? ST_CL_SHIFT : ST_CL_QRD;
            ST_CL_SHIFT:    state_next = sts.shift_done ? ST_CL_SCAN_RD : ST_CL_SHIFT;
            ST_CL_SCAN_RD:  state_next = sts.scan_done ? ST_DONE : ST_CL_SCAN_CHK;
            ST_CL_SCAN_CHK: state_next = sts.scan_done ? ST_DONE : ST_CL_SCAN_RD;
            ST_CU_RD:       state_next = sts.cu_done ? ST_DONE : ST_CU_WR;
            ST_CU_WR:       state_next = ST_CU_RD;
            ST_DONE:        state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.load       = (state_reg == ST_IDLE) && in_valid && in_ready;
        cmd.exec       = (state_reg == ST_EXEC);
        cmd.rd_capture = (state_reg == ST_RD_WAIT);
        cmd.cl_first   = (state_reg == ST_CL_FIRST);
        cmd.q_issue    = (state_reg == ST_CL_QRD);
        cmd.q_check    = (state_reg == ST_CL_QCHK);
        cmd.q_shift    = (state_reg == ST_CL_SHIFT);
        cmd.scan_issue = (state_reg == ST_CL_SCAN_RD);
        cmd.scan_check = (state_reg == ST_CL_SCAN_CHK);
        cmd.cu_issue   = (state_reg == ST_CU_RD);
        cmd.cu_write   = (state_reg == ST_CU_WR);
        cmd.out_load   = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/twb_dp.sv =====
`default_nettype none
module twb_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [63:0]   cfg_data,
    input  wire logic [2:0]    action,
    input  wire logic [63:0]   time_value,
    input  wire logic [31:0]   event_payload,
    input  wire logic [8:0]    cull_count,
    input  wire logic [7:0]    read_index,
    input  wire twb_pkg::cmd_t cmd,
    output twb_pkg::sts_t      sts,
    output logic               accepted,
    output logic [8:0]         ready_count,
    output logic [63:0]        batch_ref_time,
    output logic [63:0]        entry_time,
    output logic [31:0]        entry_payload
);
    import twb_pkg::*;

    logic [63:0]             ev_time_mem [EVENT_DEPTH];
    logic [PAYLOAD_BITS-1:0] ev_data_mem [EVENT_DEPTH];
    logic [63:0]             ref_mem     [REF_DEPTH];

    logic [63:0]  offset_reg;
    logic [EV_CW-1:0]  fill_reg;
    logic [63:0]  cur_ref_reg;
    logic [REF_CW-1:0] ref_fill_reg;

    logic [2:0]   act_reg;
    logic [63:0]  tv_reg;
    logic [PAYLOAD_BITS-1:0] pl_reg;
    logic [8:0]   cull_reg;
    logic [7:0]   ridx_reg;

    // event memory port
    logic              ev_we;
    logic [EV_AW-1:0]  ev_waddr, ev_raddr;
    logic [63:0]       ev_wtime;
    logic [PAYLOAD_BITS-1:0] ev_wdata;
    logic [63:0]       ev_rtime_reg;
    logic [PAYLOAD_BITS-1:0] ev_rdata_reg;

    // reference memory port
    logic              rq_we;
    logic [REF_AW-1:0] rq_waddr, rq_raddr;
    logic [63:0]       rq_wdata, rq_rdata_reg;

    // sequencing
    logic [EV_CW-1:0]  idx_reg;   // event index / cull destination
    logic [EV_CW-1:0]  ncull_reg;
    logic [REF_CW-1:0] qi_reg;    // queue walk, counts down
    logic [REF_CW-1:0] k_reg;
    logic [REF_CW-1:0] sh_reg;
    logic              sh_ph_reg;
    logic [63:0]       first_reg;
    logic [63:0]       end_reg;
    logic              first_ok_reg;

    logic              acc_reg;
    logic [8:0]        cnt_reg;
    logic [63:0]       bref_reg, et_reg;
    logic [31:0]       ep_reg;

    logic [EV_CW-1:0]  ncull;
    logic [63:0]       cur_win;
    logic              q_hit;

    assign ncull   = ({1'b0, cull_reg} > 10'(fill_reg)) ? fill_reg : EV_CW'(cull_reg);
    assign cur_win = sat_add(cur_ref_reg, offset_reg);
    assign q_hit   = (rq_rdata_reg < first_reg) && (sat_add(rq_rdata_reg, offset_reg) > first_reg);

    assign sts.action      = action_t'(act_reg);
    assign sts.close_empty = (fill_reg == '0);
    assign sts.q_done      = (qi_reg == '0);
    assign sts.q_found     = q_hit;
    assign sts.shift_done  = (sh_reg + k_reg >= ref_fill_reg) && sh_ph_reg;
    assign sts.scan_done   = first_ok_reg || (idx_reg == fill_reg);
    assign sts.cu_done     = (idx_reg + ncull_reg >= fill_reg);

    always_comb
    begin
        ev_we    = 1'b0;
        ev_waddr = EV_AW'(fill_reg);
        ev_wtime = tv_reg;
        ev_wdata = pl_reg;
        ev_raddr = EV_AW'(ridx_reg);
        rq_we    = 1'b0;
        rq_waddr = REF_AW'(ref_fill_reg);
        rq_wdata = tv_reg;
        rq_raddr = REF_AW'(qi_reg - 1'b1);
        if (cmd.exec && act_reg == ACT_ADD_EVENT && fill_reg < EV_CW'(EVENT_DEPTH))
            ev_we = 1'b1;
        if (cmd.exec && act_reg == ACT_ADD_REF && cur_ref_reg != '0
            && ref_fill_reg < REF_CW'(REF_DEPTH))
            rq_we = 1'b1;
        if (cmd.exec && act_reg == ACT_CLOSE)
            ev_raddr = '0;
        if (cmd.scan_issue)
            ev_raddr = EV_AW'(idx_reg);
        if (cmd.cu_issue)
            ev_raddr = EV_AW'(idx_reg + ncull_reg);
        if (cmd.cu_write)
        begin
            ev_we    = 1'b1;
            ev_waddr = EV_AW'(idx_reg);
            ev_wtime = ev_rtime_reg;
            ev_wdata = ev_rdata_reg;
        end
        if (cmd.q_shift)
        begin
            rq_raddr = REF_AW'(sh_reg + k_reg);
            rq_we    = sh_ph_reg && (sh_reg + k_reg < ref_fill_reg);
            rq_waddr = REF_AW'(sh_reg);
            rq_wdata = rq_rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_we)
        begin
            ev_time_mem[ev_waddr] <= ev_wtime;
            ev_data_mem[ev_waddr] <= ev_wdata;
        end
        ev_rtime_reg <= ev_time_mem[ev_raddr];
        ev_rdata_reg <= ev_data_mem[ev_raddr];
        if (rq_we)
            ref_mem[rq_waddr] <= rq_wdata;
        rq_rdata_reg <= ref_mem[rq_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            tv_reg   <= time_value;
            pl_reg   <= event_payload[PAYLOAD_BITS-1:0];
            cull_reg <= cull_count;
            ridx_reg <= read_index;
            acc_reg  <= 1'b0;
            cnt_reg  <= '0;
            bref_reg <= '0;
            et_reg   <= '0;
            ep_reg   <= '0;
        end
        if (cmd.exec)
        begin
            idx_reg      <= '0;
            ncull_reg    <= ncull;
            qi_reg       <= ref_fill_reg;
            sh_reg       <= '0;
            sh_ph_reg    <= 1'b0;
            first_ok_reg <= 1'b0;
            case (action_t'(act_reg))
                ACT_ADD_EVENT: acc_reg <= (fill_reg < EV_CW'(EVENT_DEPTH));
                ACT_ADD_REF:   acc_reg <= (cur_ref_reg == '0) || (ref_fill_reg < REF_CW'(REF_DEPTH));
                ACT_REPORT:
                begin
                    if (fill_reg != '0)
                    begin
                        cnt_reg  <= 9'(fill_reg);
                        bref_reg <= cur_ref_reg;
                    end
                end
                default: ;
            endcase
        end
        if (cmd.rd_capture && {1'b0, ridx_reg} < 9'(fill_reg))
        begin
            et_reg <= ev_rtime_reg;
            ep_reg <= 32'(ev_rdata_reg);
        end
        if (cmd.cl_first)
            first_reg <= ev_rtime_reg;
        if (cmd.q_issue)
            qi_reg <= qi_reg - 1'b1;
        if (cmd.q_check && q_hit)
            k_reg <= qi_reg;
        if (cmd.q_shift)
        begin
            sh_ph_reg <= ~sh_ph_reg;
            if (sh_ph_reg)
                sh_reg <= sh_reg + 1'b1;
        end
        if (cmd.scan_issue)
            end_reg <= cur_win;
        if (cmd.scan_check)
        begin
            if (ev_rtime_reg > end_reg)
            begin
                first_ok_reg <= 1'b1;
                cnt_reg      <= 9'(idx_reg);
                bref_reg     <= cur_ref_reg;
            end
            else
            begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + 1'b1 == EV_CW'(EVENT_DEPTH))
                begin
                    cnt_reg  <= 9'(EVENT_DEPTH);
                    bref_reg <= cur_ref_reg;
                end
            end
        end
        if (cmd.cu_write)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.out_load)
        begin
            accepted       <= acc_reg;
            ready_count    <= cnt_reg;
            batch_ref_time <= bref_reg;
            entry_time     <= et_reg;
            entry_payload  <= ep_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= OFFSET_RESET;
            fill_reg     <= '0;
            cur_ref_reg  <= '0;
            ref_fill_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                offset_reg <= cfg_data;
            if (cmd.exec)
            begin
                case (action_t'(act_reg))
                    ACT_ADD_EVENT: if (fill_reg < EV_CW'(EVENT_DEPTH)) fill_reg <= fill_reg + 1'b1;
                    ACT_ADD_REF:
                    begin
                        if (cur_ref_reg == '0)
                            cur_ref_reg <= tv_reg;
                        else if (ref_fill_reg < REF_CW'(REF_DEPTH))
                            ref_fill_reg <= ref_fill_reg + 1'b1;
                    end
                    ACT_CLEAR: fill_reg <= '0;
                    default: ;
                endcase
            end
            if (cmd.cl_first && (cur_ref_reg == '0 || cur_win < ev_rtime_reg))
                cur_ref_reg <= ev_rtime_reg;
            if (cmd.q_check && q_hit)
                cur_ref_reg <= rq_rdata_reg;
            if (cmd.q_shift && sts.shift_done)
                ref_fill_reg <= ref_fill_reg - k_reg;
            if (cmd.cu_issue && sts.cu_done)
                fill_reg <= fill_reg - ncull_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/twb_checker.sv =====
`default_nettype none
module twb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        accepted,
    input wire logic [8:0]  ready_count,
    input wire logic [63:0] batch_ref_time
);
    // no new item while an earlier result is pending and not taken
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready) else $error("item taken over stalled result");
    // ready stays low while an accepted item is being executed
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ready_count <= 9'd256) else $error("ready_count out of range");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(batch_ref_time) && $stable(accepted))
        else $error("stalled result changed");
endmodule

bind time_window_event_batcher twb_checker u_twb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .accepted       (out_ch.accepted),
    .ready_count    (out_ch.ready_count),
    .batch_ref_time (out_ch.batch_ref_time)
);
`default_nettype wire

// ===== tb/tb_time_window_event_batcher.sv =====
`default_nettype none
module tb_time_window_event_batcher;
    timeunit 1ns;
    timeprecision 1ps;
    import twb_pkg::*;

    // action code 7 has no meaning; the block must answer it with an all-zero result
    localparam logic [2:0] ACT_UNKNOWN = 3'd7;
    localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int IDLE_LIMIT          = 50000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES         = 400;    // long receiver hold-off
    localparam int PHASE_ITEMS         = 320;

    typedef struct {
        logic [2:0]  act;
        logic [63:0] tv;
        logic [31:0] pl;
        logic [8:0]  cc;
        logic [7:0]  ri;
    } cmd_item_t;

    typedef struct {
        logic        acc;
        logic [8:0]  cnt;
        logic [63:0] bref;
        logic [63:0] et;
        logic [31:0] ep;
    } batch_res_t;

    // directed row: command plus an optional hand-typed answer
    typedef struct {
        cmd_item_t  cmd;
        bit         typed;
        batch_res_t ans;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [63:0] cfg_data;

    twb_in_if  in_ch ();
    twb_out_if out_ch ();

    time_window_event_batcher u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the batcher state
    // ---------------------------------------------------------------
    logic [63:0] sh_offset;
    logic [63:0] sh_ev_time [EVENT_DEPTH];
    logic [31:0] sh_ev_data [EVENT_DEPTH];
    int          sh_fill;
    logic [63:0] sh_cur_ref;
    logic [63:0] sh_ref_q [REF_DEPTH];
    int          sh_ref_fill;

    batch_res_t  pending_results[$];
    int          n_errors;
    int          n_sent;
    int          n_checked;
    int          n_full_refusals;
    int          n_batches;
    bit          xfer_seen;

    // receiver control, shared with the main thread
    bit          hold_request;
    bit          no_idle;

    // saturating window end
    function automatic logic [63:0] window_end(input logic [63:0] base, input logic [63:0] span);
        logic [64:0] s;
        s = {1'b0, base} + {1'b0, span};
        window_end = s[64] ? ALL_ONES : s[63:0];
    endfunction

    task automatic close_batch(output logic [8:0] cnt, output logic [63:0] bref);
        logic [63:0] first;
        logic [63:0] lim;
        int          k;
        bit          found;
        cnt   = '0;
        bref  = '0;
        found = 1'b0;
        k     = 0;
        if (sh_fill == 0)
            return;
        first = sh_ev_time[0];
        // re-base an unset or stale reference onto the oldest event
        if (sh_cur_ref == 0 || window_end(sh_cur_ref, sh_offset) < first)
            sh_cur_ref = first;
        // newest queued reference whose window holds the oldest event wins
        for (int i = sh_ref_fill; i != 0; i--)
        begin
            if (!found && sh_ref_q[i-1] < first && window_end(sh_ref_q[i-1], sh_offset) > first)
            begin
                k     = i - 1;
                found = 1'b1;
            end
        end
        if (found)
        begin
            sh_cur_ref = sh_ref_q[k];
            for (int i = 0; i + k < sh_ref_fill; i++)
                sh_ref_q[i] = sh_ref_q[i+k];
            sh_ref_fill -= k;
        end
        lim = window_end(sh_cur_ref, sh_offset);
        for (int n = 0; n < sh_fill; n++)
        begin
            if (sh_ev_time[n] > lim)
            begin
                cnt  = n[8:0];
                bref = sh_cur_ref;
                return;
            end
        end
        if (sh_fill == EVENT_DEPTH)
        begin
            cnt  = 9'(EVENT_DEPTH);
            bref = sh_cur_ref;
        end
    endtask

    task automatic predict_batch(input cmd_item_t c, output batch_res_t r);
        int n;
        r = '{default: '0};
        case (c.act)
            ACT_ADD_EVENT:
                if (sh_fill < EVENT_DEPTH)
                begin
                    sh_ev_time[sh_fill] = c.tv;
                    sh_ev_data[sh_fill] = c.pl;
                    sh_fill++;
                    r.acc = 1'b1;
                end
            ACT_ADD_REF:
                if (sh_cur_ref == 0)
                begin
                    sh_cur_ref = c.tv;
                    r.acc      = 1'b1;
                end
                else if (sh_ref_fill < REF_DEPTH)
                begin
                    sh_ref_q[sh_ref_fill] = c.tv;
                    sh_ref_fill++;
                    r.acc = 1'b1;
                end
            ACT_CLOSE:
                close_batch(r.cnt, r.bref);
            ACT_REPORT:
                if (sh_fill != 0)
                begin
                    r.cnt  = sh_fill[8:0];
                    r.bref = sh_cur_ref;
                end
            ACT_CULL:
            begin
                n = (int'(c.cc) > sh_fill) ? sh_fill : int'(c.cc);
                for (int i = 0; i + n < sh_fill; i++)
                begin
                    sh_ev_time[i] = sh_ev_time[i+n];
                    sh_ev_data[i] = sh_ev_data[i+n];
                end
                sh_fill -= n;
            end
            ACT_CLEAR:
                sh_fill = 0;
            ACT_READ:
                if (int'(c.ri) < sh_fill)
                begin
                    r.et = sh_ev_time[c.ri];
                    r.ep = sh_ev_data[c.ri];
                end
            default: ;
        endcase
        if ((c.act == ACT_ADD_EVENT || c.act == ACT_ADD_REF) && !r.acc)
            n_full_refusals++;
        if (c.act == ACT_CLOSE && (r.cnt != 0 || r.bref != 0))
            n_batches++;
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        n_errors++;
        $display("mismatch at result %0d: %s got %h want %h", n_checked, field, got, want);
    endtask

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic send_item(input cmd_item_t c, input bit typed, input batch_res_t ans);
        int         gap;
        batch_res_t r;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= c.act;
        in_ch.time_value    <= c.tv;
        in_ch.event_payload <= c.pl;
        in_ch.cull_count    <= c.cc;
        in_ch.read_index    <= c.ri;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_batch(c, r);
        pending_results.insert(pending_results.size(), typed ? ans : r);
        n_sent++;
    endtask

    // register writes only once the block has drained
    task automatic write_offset(input logic [63:0] v);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sh_offset  = v;
    endtask

    function automatic logic [63:0] rand64();
        rand64 = {$urandom(), $urandom()};
    endfunction

    // ---------------------------------------------------------------
    // Receiver side: per-result stall, plus the long hold-off on request
    // ---------------------------------------------------------------
    initial
    begin
        int         stall;
        batch_res_t want;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                xfer_seen = 1'b1;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    $display("result transfer with nothing pending");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_ch.accepted !== want.acc)
                        report_mismatch("accepted", 64'(out_ch.accepted), 64'(want.acc));
                    if (out_ch.ready_count !== want.cnt)
                        report_mismatch("ready_count", 64'(out_ch.ready_count), 64'(want.cnt));
                    if (out_ch.batch_ref_time !== want.bref)
                        report_mismatch("batch_ref_time", out_ch.batch_ref_time, want.bref);
                    if (out_ch.entry_time !== want.et)
                        report_mismatch("entry_time", out_ch.entry_time, want.et);
                    if (out_ch.entry_payload !== want.ep)
                        report_mismatch("entry_payload", 64'(out_ch.entry_payload),
                                        64'(want.ep));
                    n_checked++;
                end
                stall = no_idle ? 0 : $urandom_range(0, 16);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog: input transfers also count as progress
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
                xfer_seen = 1'b1;
            quiet     = xfer_seen ? 0 : quiet + 1;
            xfer_seen = 1'b0;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Random item with a phase-dependent action mix
    // ---------------------------------------------------------------
    logic [63:0] t_base;

    function automatic cmd_item_t make_item(input int w_ev, input int w_ref, input int w_close,
                                            input logic [31:0] step);
        cmd_item_t c;
        int        roll;
        c.tv = '0;
        c.pl = $urandom();
        c.cc = $urandom_range(0, 3) == 0 ? 9'($urandom()) : 9'($urandom_range(0, 24));
        c.ri = $urandom_range(0, 1) ? 8'($urandom()) : 8'($urandom_range(0, 8));
        roll = $urandom_range(0, 99);
        if (roll < w_ev)
        begin
            c.act  = ACT_ADD_EVENT;
            t_base = t_base + 64'($urandom_range(0, step));
            c.tv   = ($urandom_range(0, 24) == 0) ? rand64() : t_base;
        end
        else if (roll < w_ev + w_ref)
        begin
            c.act = ACT_ADD_REF;
            c.tv  = ($urandom_range(0, 24) == 0) ? rand64()
                                                  : t_base - 64'($urandom_range(0, step));
        end
        else if (roll < w_ev + w_ref + w_close)
            c.act = ACT_CLOSE;
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:    c.act = ACT_REPORT;
                2, 3:    c.act = ACT_CULL;
                4:       c.act = ($urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_CULL;
                5:       c.act = ACT_UNKNOWN;
                default: c.act = ACT_READ;
            endcase
            c.tv = rand64();
        end
        make_item = c;
    endfunction

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    dir_row_t dir_rows[$];

    function automatic dir_row_t row(input logic [2:0] a, input logic [63:0] tv,
                                     input logic [31:0] pl, input logic [8:0] cc,
                                     input logic [7:0] ri, input bit typed,
                                     input logic acc, input logic [63:0] et,
                                     input logic [31:0] ep);
        dir_row_t d;
        d.cmd   = '{act: a, tv: tv, pl: pl, cc: cc, ri: ri};
        d.typed = typed;
        d.ans   = '{acc: acc, cnt: '0, bref: '0, et: et, ep: ep};
        row = d;
    endfunction

    function automatic void queue_row(input dir_row_t d);
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    initial
    begin
        batch_res_t  none;
        logic [63:0] offs [5];
        logic [31:0] steps [5];
        int          w_ev [5];
        int          w_ref [5];
        int          w_close [5];

        n_errors = 0; n_sent = 0; n_checked = 0; n_full_refusals = 0; n_batches = 0;
        hold_request = 1'b0; no_idle = 1'b0; xfer_seen = 1'b0;
        none = '{default: '0};
        sh_offset   = OFFSET_RESET;
        sh_fill     = 0;
        sh_cur_ref  = '0;
        sh_ref_fill = 0;
        t_base      = 64'd1000;

        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= '0;
        in_ch.time_value    <= '0;
        in_ch.event_payload <= '0;
        in_ch.cull_count    <= '0;
        in_ch.read_index    <= '0;
        out_ch.ready        <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty-store answers, extremes, each action
        queue_row(row(ACT_REPORT, ALL_ONES, '1, '1, '1, 1, 0, 0, 0));
        queue_row(row(ACT_CLOSE, 0, 0, 0, 0, 1, 0, 0, 0));
        queue_row(row(ACT_READ, 0, 0, 0, 0, 1, 0, 0, 0));
        queue_row(row(ACT_CULL, 0, 0, '1, 0, 1, 0, 0, 0));
        // reference while unset goes straight to current, the next one is queued
        queue_row(row(ACT_ADD_REF, 64'd100, 0, 0, 0, 1, 1, 0, 0));
        queue_row(row(ACT_ADD_REF, 64'd50, 0, 0, 0, 1, 1, 0, 0));
        queue_row(row(ACT_ADD_EVENT, 0, 0, 0, 0, 1, 1, 0, 0));
        queue_row(row(ACT_ADD_EVENT, ALL_ONES, '1, 0, 0, 1, 1, 0, 0));
        queue_row(row(ACT_READ, 0, 0, 0, 8'd1, 1, 0, ALL_ONES, '1));
        queue_row(row(ACT_READ, 0, 0, 0, 8'd2, 1, 0, 0, 0));
        queue_row(row(ACT_READ, 0, 0, 0, '1, 1, 0, 0, 0));
        queue_row(row(ACT_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_REPORT, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_UNKNOWN, ALL_ONES, '1, '1, '1, 1, 0, 0, 0));
        // cull beyond the fill clamps
        queue_row(row(ACT_CULL, 0, 0, 9'd300, 0, 1, 0, 0, 0));
        queue_row(row(ACT_ADD_EVENT, 64'd5000000, 32'h1234_5678, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_ADD_EVENT, 64'd5200000, 32'h0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_ADD_EVENT, 64'd7000000, 32'h5555_aaaa, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_ADD_REF, 64'd4500000, 0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_CULL, 0, 0, 9'd1, 0, 0, 0, 0, 0));
        queue_row(row(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_row(row(ACT_CLEAR, 0, 0, 0, 0, 1, 0, 0, 0));
        queue_row(row(ACT_REPORT, 0, 0, 0, 0, 1, 0, 0, 0));

        foreach (dir_rows[i])
            send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].ans);

        // phases: default, zero window, widest window, narrow, fill-to-full
        offs[0] = OFFSET_RESET;  steps[0] = 32'd300000;
        offs[1] = '0;            steps[1] = 32'd3;
        offs[2] = ALL_ONES;      steps[2] = '1;
        offs[3] = 64'($urandom_range(1000, 500000));
        steps[3] = 32'(offs[3] / 3) + 1;
        offs[4] = 64'd20000;     steps[4] = 32'd20;
        w_ev[0] = 40; w_ref[0] = 15; w_close[0] = 15;
        w_ev[1] = 40; w_ref[1] = 30; w_close[1] = 8;
        w_ev[2] = 45; w_ref[2] = 15; w_close[2] = 15;
        w_ev[3] = 40; w_ref[3] = 15; w_close[3] = 20;
        w_ev[4] = 85; w_ref[4] = 8;  w_close[4] = 5;

        for (int p = 0; p < 5; p++)
        begin
            write_offset(offs[p]);
            t_base = ($urandom_range(0, 3) == 0) ? ALL_ONES - 64'd100000000 : rand64() >> 2;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // a burst with no idling on either side in the middle of each phase
                no_idle = (i >= 100 && i < 140);
                // the receiver holds off while the sender keeps offering
                if (i == 200 && (p == 0 || p == 4))
                    hold_request = 1'b1;
                send_item(make_item(w_ev[p], w_ref[p], w_close[p], steps[p]), 0, none);
            end
            no_idle = 1'b0;
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d commands over five window widths, checked %0d results",
                 n_sent, n_checked);
        $display("%0d refused adds on full stores, %0d closed batches reported",
                 n_full_refusals, n_batches);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
